/* rtl/core/ahcfp_pkg.sv */
// ============================================================================
// ahcfp_pkg
// Shared constants, types and hex decoding functions for the ASCII hex
// control frame parser.
// ============================================================================
package ahcfp_pkg;

    localparam logic [7:0] START_MARK = 8'h21;
    localparam logic [7:0] ID_CONTROL = 8'h63;
    localparam logic [7:0] ID_PAD_ONE = 8'h6A;
    localparam logic [7:0] ID_PAD_TWO = 8'h4A;
    localparam logic [7:0] DIGIT_LAST = 8'h39;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] ALPHA_BIAS = 8'h37;

    localparam int         STORE_DEPTH = 20;
    localparam logic [4:0] CONTROL_LEN = 5'd10;
    localparam logic [4:0] PAD_LEN     = 5'd22;
    localparam logic [4:0] CHECK_GAP   = 5'd4;
    localparam logic [4:0] POS_HUNT    = 5'd0;
    localparam logic [4:0] POS_ID      = 5'd1;
    localparam logic [4:0] POS_BODY    = 5'd2;

    localparam logic [1:0] KIND_CONTROL = 2'd0;
    localparam logic [1:0] KIND_PAD_ONE = 2'd1;
    localparam logic [1:0] KIND_PAD_TWO = 2'd2;

    typedef logic [STORE_DEPTH-1:0][7:0] t_frame_bytes;

    typedef struct packed {
        logic [1:0]        packet_kind;
        logic [3:0]        drive_mode;
        logic              enable_flag;
        logic              estop_flag;
        logic [7:0]        switch_bits;
        logic [15:0]       button_bits;
        logic signed [7:0] axis_left_x;
        logic signed [7:0] axis_left_y;
        logic signed [7:0] axis_right_x;
        logic signed [7:0] axis_right_y;
        logic signed [7:0] trigger_left;
        logic signed [7:0] trigger_right;
    } t_result;

    function automatic logic [7:0] hex_digit(input logic [7:0] c);
        if (c <= DIGIT_LAST) begin
            return c - DIGIT_ZERO;
        end
        return c - ALPHA_BIAS;
    endfunction

    function automatic logic [7:0] hex_byte(input logic [7:0] c1, input logic [7:0] c0);
        logic [7:0] d1;
        d1 = hex_digit(c1);
        return {d1[3:0], 4'b0000} + hex_digit(c0);
    endfunction

    function automatic logic [15:0] hex_word(input logic [7:0] c3, input logic [7:0] c2,
                                             input logic [7:0] c1, input logic [7:0] c0);
        logic [7:0] d3;
        d3 = hex_digit(c3);
        return {d3[3:0], 12'h000} + {hex_digit(c2), 8'h00}
             + {4'h0, hex_digit(c1), 4'h0} + {8'h00, hex_digit(c0)};
    endfunction

endpackage

/* rtl/core/ahcfp_if.sv */
// ============================================================================
// ahcfp_byte_if / ahcfp_result_if
// Valid/ready channels for received bytes and for decoded frame results.
// ============================================================================
interface ahcfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface ahcfp_result_if;
    logic              valid;
    logic              ready;
    logic [1:0]        packet_kind;
    logic [3:0]        drive_mode;
    logic              enable_flag;
    logic              estop_flag;
    logic [7:0]        switch_bits;
    logic [15:0]       button_bits;
    logic signed [7:0] axis_left_x;
    logic signed [7:0] axis_left_y;
    logic signed [7:0] axis_right_x;
    logic signed [7:0] axis_right_y;
    logic signed [7:0] trigger_left;
    logic signed [7:0] trigger_right;

    modport source (output valid, output packet_kind, output drive_mode, output enable_flag,
                    output estop_flag, output switch_bits, output button_bits,
                    output axis_left_x, output axis_left_y, output axis_right_x,
                    output axis_right_y, output trigger_left, output trigger_right,
                    input ready);
    modport sink   (input valid, input packet_kind, input drive_mode, input enable_flag,
                    input estop_flag, input switch_bits, input button_bits,
                    input axis_left_x, input axis_left_y, input axis_right_x,
                    input axis_right_y, input trigger_left, input trigger_right,
                    output ready);
endinterface

/* rtl/core/ahcfp_decode.sv */
// ============================================================================
// ahcfp_decode
// Decodes the stored frame bytes into result fields and checks the sum.
// ============================================================================
module ahcfp_decode (
    input  ahcfp_pkg::t_frame_bytes i_frame,
    input  logic [1:0]              i_kind,
    input  logic [7:0]              i_sum,
    output logic                    o_check_ok,
    output ahcfp_pkg::t_result      o_result
);
    import ahcfp_pkg::*;

    logic [7:0] check_byte;
    logic [7:0] control_word;

    always_comb begin
        check_byte   = (i_kind == KIND_CONTROL) ? hex_byte(i_frame[6], i_frame[7])
                                                : hex_byte(i_frame[18], i_frame[19]);
        o_check_ok   = (check_byte == i_sum);
        control_word = hex_byte(i_frame[2], i_frame[3]);
        o_result     = '0;
        o_result.packet_kind = i_kind;
        if (i_kind == KIND_CONTROL) begin
            o_result.drive_mode  = control_word[3:0];
            o_result.enable_flag = control_word[4];
            o_result.estop_flag  = control_word[5];
            o_result.switch_bits = hex_byte(i_frame[4], i_frame[5]);
        end else begin
            o_result.button_bits   = hex_word(i_frame[2], i_frame[3], i_frame[4], i_frame[5]);
            o_result.axis_left_x   = hex_byte(i_frame[6], i_frame[7]);
            o_result.axis_left_y   = hex_byte(i_frame[8], i_frame[9]);
            o_result.axis_right_x  = hex_byte(i_frame[10], i_frame[11]);
            o_result.axis_right_y  = hex_byte(i_frame[12], i_frame[13]);
            o_result.trigger_left  = hex_byte(i_frame[14], i_frame[15]);
            o_result.trigger_right = hex_byte(i_frame[16], i_frame[17]);
        end
    end

endmodule

/* rtl/core/ascii_hex_control_frame_parser.sv */
// ============================================================================
// ascii_hex_control_frame_parser
// Parses '!'-started ASCII hex control and gamepad frames from a byte stream.
// ============================================================================
// Throughput is one byte per cycle unless a finished result must wait; each
// byte passes an input register and then updates the frame state. A good
// frame's last byte passes the input register, then its result is registered
// and valid; while it waits, input stalls only at another good frame's end.
// Reset clears the position, kind, sum and both valid flags; the stored
// frame bytes are not reset.
module ascii_hex_control_frame_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ahcfp_byte_if.sink            i_byte,
    ahcfp_result_if.source        o_result
);
    import ahcfp_pkg::*;

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic [4:0]   r_pos,  n_pos;
    logic [1:0]   r_kind, n_kind;
    logic [7:0]   r_sum,  n_sum;
    t_frame_bytes r_frame;
    logic         r_out_valid;
    t_result      r_result;

    logic         stage_go;
    logic         wr_en;
    logic [4:0]   wr_idx;
    logic         emit;
    logic [4:0]   frame_len;
    logic         check_ok;
    t_result      dec_result;

    ahcfp_decode u_decode (
        .i_frame    (r_frame),
        .i_kind     (r_kind),
        .i_sum      (r_sum),
        .o_check_ok (check_ok),
        .o_result   (dec_result)
    );

    assign stage_go     = r_in_valid && (!emit || !r_out_valid || o_result.ready);
    assign i_byte.ready = !r_in_valid || stage_go;

    always_comb begin
        n_pos     = r_pos;
        n_kind    = r_kind;
        n_sum     = r_sum;
        wr_en     = 1'b0;
        wr_idx    = r_pos;
        emit      = 1'b0;
        frame_len = (r_kind == KIND_CONTROL) ? CONTROL_LEN : PAD_LEN;
        if (r_in_byte == START_MARK) begin
            wr_en  = 1'b1;
            wr_idx = POS_HUNT;
            n_sum  = r_in_byte;
            n_pos  = POS_ID;
        end else if (r_pos == POS_HUNT) begin
            n_pos = POS_HUNT;
        end else if (r_pos == POS_ID) begin
            n_pos = POS_BODY;
            wr_en = 1'b1;
            n_sum = r_sum + r_in_byte;
            if (r_in_byte == ID_CONTROL) begin
                n_kind = KIND_CONTROL;
            end else if (r_in_byte == ID_PAD_ONE) begin
                n_kind = KIND_PAD_ONE;
            end else if (r_in_byte == ID_PAD_TWO) begin
                n_kind = KIND_PAD_TWO;
            end else begin
                n_pos = POS_HUNT;
                wr_en = 1'b0;
                n_sum = r_sum;
            end
        end else if (r_pos >= frame_len) begin
            n_pos = POS_HUNT;
        end else begin
            if (r_pos < frame_len - CHECK_GAP) begin
                n_sum = r_sum + r_in_byte;
            end
            wr_en = (r_pos < 5'(STORE_DEPTH));
            if (r_pos + 5'd1 < frame_len) begin
                n_pos = r_pos + 5'd1;
            end else begin
                n_pos = POS_HUNT;
                emit  = check_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= POS_HUNT;
            r_kind      <= KIND_CONTROL;
            r_sum       <= 8'h00;
        end else begin
            if (i_byte.ready) begin
                r_in_valid <= i_byte.valid;
            end
            if (stage_go) begin
                r_pos  <= n_pos;
                r_kind <= n_kind;
                r_sum  <= n_sum;
            end
            r_out_valid <= (r_out_valid && !o_result.ready) || (stage_go && emit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
        end
        if (stage_go && emit) begin
            r_result <= dec_result;
        end
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (stage_go && wr_en && (wr_idx == 5'(i))) begin
                r_frame[i] <= r_in_byte;
            end
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.packet_kind   = r_result.packet_kind;
    assign o_result.drive_mode    = r_result.drive_mode;
    assign o_result.enable_flag   = r_result.enable_flag;
    assign o_result.estop_flag    = r_result.estop_flag;
    assign o_result.switch_bits   = r_result.switch_bits;
    assign o_result.button_bits   = r_result.button_bits;
    assign o_result.axis_left_x   = r_result.axis_left_x;
    assign o_result.axis_left_y   = r_result.axis_left_y;
    assign o_result.axis_right_x  = r_result.axis_right_x;
    assign o_result.axis_right_y  = r_result.axis_right_y;
    assign o_result.trigger_left  = r_result.trigger_left;
    assign o_result.trigger_right = r_result.trigger_right;

endmodule

/* rtl/core/ahcfp_checker.sv */
// ============================================================================
// ahcfp_checker
// Port-level checks of the frame parser's result channel.
// ============================================================================
module ahcfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_packet_kind,
    input logic [3:0]  i_drive_mode,
    input logic        i_enable_flag,
    input logic        i_estop_flag,
    input logic [7:0]  i_switch_bits,
    input logic [15:0] i_button_bits,
    input logic [7:0]  i_axis_or
);
    import ahcfp_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("stalled result request dropped");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_packet_kind == KIND_CONTROL || i_packet_kind == KIND_PAD_ONE
                         || i_packet_kind == KIND_PAD_TWO))
        else $error("unknown packet kind on result");

    a_control_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_packet_kind == KIND_CONTROL |-> i_button_bits == 16'h0000
                                                       && i_axis_or == 8'h00)
        else $error("gamepad fields set on a control frame");

    a_pad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_packet_kind != KIND_CONTROL |-> i_drive_mode == 4'h0
            && !i_enable_flag && !i_estop_flag && i_switch_bits == 8'h00)
        else $error("control fields set on a gamepad frame");

endmodule

bind ascii_hex_control_frame_parser ahcfp_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_packet_kind (o_result.packet_kind),
    .i_drive_mode  (o_result.drive_mode),
    .i_enable_flag (o_result.enable_flag),
    .i_estop_flag  (o_result.estop_flag),
    .i_switch_bits (o_result.switch_bits),
    .i_button_bits (o_result.button_bits),
    .i_axis_or     (o_result.axis_left_x | o_result.axis_left_y | o_result.axis_right_x
                    | o_result.axis_right_y | o_result.trigger_left
                    | o_result.trigger_right)
);
